// ----- hw/rtl/lcslis_pkg.sv -----
// shared types, command codes and field widths for the lcs-by-lis block
package lcslis_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 10;
    localparam int LEN_W   = 11;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_B     = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic begin_b;
        logic scan;
        logic miss;
        logic srch;
        logic srch_step;
        logic update;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_hit;
        logic scan_empty;
        logic srch_more;
    } dp_stat_t;

endpackage

// ----- hw/rtl/lcslis_ctrl.sv -----
// control state machine: command decode, a scan, binary search, tails update
module lcslis_ctrl
    import lcslis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] cmd,
    input  dp_stat_t   stat,
    output dp_cmd_t    dp_cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE, ST_FINISH:
            begin
                if (accept && cmd == CMD_B)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    state_next = ST_SRCH;
                end
                else if (stat.scan_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SRCH:
            begin
                if (stat.srch_more)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_SRCH_CMP:
            begin
                state_next = ST_SRCH;
            end
            ST_UPDATE:
            begin
                state_next = ST_FINISH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dp_cmd = '0;
        busy   = 1'b1;
        done   = 1'b0;
        case (state_reg)
            ST_IDLE, ST_FINISH:
            begin
                busy           = 1'b0;
                done           = (state_reg == ST_FINISH);
                dp_cmd.load    = start && cmd == CMD_LOAD;
                dp_cmd.clear   = start && cmd == CMD_CLEAR;
                dp_cmd.begin_b = start && cmd == CMD_B;
            end
            ST_SCAN:
            begin
                dp_cmd.scan = 1'b1;
                dp_cmd.miss = !stat.scan_hit && stat.scan_empty;
            end
            ST_SRCH:
            begin
                dp_cmd.srch = 1'b1;
            end
            ST_SRCH_CMP:
            begin
                dp_cmd.srch_step = 1'b1;
            end
            ST_UPDATE:
            begin
                dp_cmd.update = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lcslis_dp.sv -----
// datapath: a-value memory with linear scan, tails memory, search and result registers
module lcslis_dp
    import lcslis_pkg::*;
#(
    parameter int MAX_A      = 1024,
    parameter int VALUE_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   dp_cmd,
    input  logic signed [VALUE_W-1:0] value,
    output dp_stat_t                  stat,
    output logic                      matched,
    output logic [POS_W-1:0]          a_position,
    output logic [LEN_W-1:0]          lcs_length
);

    localparam int AW = $clog2(MAX_A);
    localparam int CW = $clog2(MAX_A + 1);

    logic [VALUE_BITS-1:0] a_mem [MAX_A];
    logic [AW-1:0]         tails_mem [MAX_A];

    logic [CW-1:0]         a_count_reg;
    logic [CW-1:0]         run_len_reg;
    logic [CW-1:0]         run_len_next;
    logic [VALUE_BITS-1:0] key_reg;
    logic [CW-1:0]         scan_idx_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic                  rd_valid_reg;
    logic [VALUE_BITS-1:0] a_rd_reg;
    logic [AW-1:0]         pos_reg;
    logic [CW-1:0]         lo_reg;
    logic [CW-1:0]         hi_reg;
    logic [AW-1:0]         tails_rd_reg;
    logic                  res_matched_reg;
    logic [POS_W-1:0]      res_pos_reg;
    logic [LEN_W-1:0]      res_len_reg;

    logic [2*VALUE_W-1:0]  value_ext;
    logic [VALUE_BITS-1:0] norm_value;
    logic                  load_ok;
    logic                  scan_issue;
    logic [CW-1:0]         mid;
    logic [CW-1:0]         lo_m1;
    logic                  tails_rd_en;
    logic [AW-1:0]         tails_rd_addr;
    logic                  skip;
    logic                  tails_wr;
    logic [CW+POS_W-1:0]   pos_wide;
    logic [CW+LEN_W-1:0]   len_wide;

    // sign-extend to twice the field width, compare on the low VALUE_BITS
    assign value_ext  = {{VALUE_W{value[VALUE_W-1]}}, value};
    assign norm_value = value_ext[VALUE_BITS-1:0];

    assign load_ok    = dp_cmd.load && (a_count_reg < CW'(MAX_A));
    assign scan_issue = dp_cmd.scan && (scan_idx_reg < a_count_reg);

    assign stat.scan_hit   = rd_valid_reg && (a_rd_reg == key_reg);
    assign stat.scan_empty = !rd_valid_reg && (scan_idx_reg == a_count_reg);
    assign stat.srch_more  = lo_reg < hi_reg;

    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1 = lo_reg - 1'b1;

    // while lo < hi probe the midpoint, then fetch the predecessor tail
    assign tails_rd_en   = dp_cmd.srch && (stat.srch_more || lo_reg != '0);
    assign tails_rd_addr = stat.srch_more ? mid[AW-1:0] : lo_m1[AW-1:0];

    // equal predecessor keeps the subsequence strictly increasing
    assign skip     = (lo_reg != '0) && (tails_rd_reg == pos_reg);
    assign tails_wr = dp_cmd.update && !skip && (lo_reg < CW'(MAX_A));

    always_comb
    begin
        run_len_next = run_len_reg;
        if (tails_wr && lo_reg == run_len_reg)
        begin
            run_len_next = run_len_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            a_mem[a_count_reg[AW-1:0]] <= norm_value;
        end
        if (scan_issue)
        begin
            a_rd_reg <= a_mem[scan_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tails_wr)
        begin
            tails_mem[lo_reg[AW-1:0]] <= pos_reg;
        end
        if (tails_rd_en)
        begin
            tails_rd_reg <= tails_mem[tails_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_count_reg  <= '0;
            run_len_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.clear)
            begin
                a_count_reg <= '0;
                run_len_reg <= '0;
            end
            else
            begin
                if (load_ok)
                begin
                    a_count_reg <= a_count_reg + 1'b1;
                end
                run_len_reg <= run_len_next;
            end
            if (dp_cmd.begin_b)
            begin
                rd_valid_reg <= 1'b0;
            end
            else if (dp_cmd.scan)
            begin
                rd_valid_reg <= scan_issue;
            end
        end
    end

    assign pos_wide = {{(CW+POS_W-AW){1'b0}}, pos_reg};
    assign len_wide = {{LEN_W{1'b0}}, run_len_next};

    always_ff @(posedge clk)
    begin
        if (dp_cmd.begin_b)
        begin
            key_reg      <= norm_value;
            scan_idx_reg <= '0;
        end
        if (scan_issue)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            rd_idx_reg   <= scan_idx_reg[AW-1:0];
        end
        if (dp_cmd.scan && stat.scan_hit)
        begin
            pos_reg <= rd_idx_reg;
            lo_reg  <= '0;
            hi_reg  <= run_len_reg;
        end
        if (dp_cmd.srch_step)
        begin
            if (tails_rd_reg > pos_reg[AW-1:0])
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + 1'b1;
            end
        end
        if (dp_cmd.miss)
        begin
            res_matched_reg <= 1'b0;
            res_pos_reg     <= '0;
            res_len_reg     <= len_wide[LEN_W-1:0];
        end
        if (dp_cmd.update)
        begin
            res_matched_reg <= 1'b1;
            res_pos_reg     <= pos_wide[POS_W-1:0];
            res_len_reg     <= len_wide[LEN_W-1:0];
        end
    end

    assign matched    = res_matched_reg;
    assign a_position = res_pos_reg;
    assign lcs_length = res_len_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        a_count_reg <= CW'(MAX_A))
        else $error("a_count exceeds capacity");

    run_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_len_reg <= a_count_reg)
        else $error("lcs length exceeds loaded count");

    run_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(run_len_reg) |->
            (run_len_reg == $past(run_len_reg) + 1'b1 || run_len_reg == '0))
        else $error("lcs length moved by more than one");

    update_pos_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.update |-> (CW'(pos_reg) < a_count_reg))
        else $error("matched position outside loaded values");
`endif

endmodule

// ----- hw/rtl/lcs_via_index_map_and_lis.sv -----
// top level: longest common subsequence length via index map and increasing subsequence
//
// channel   direction  handshake                  payload
// item in   in         start & !busy              cmd, value
// result    out        done (one cycle, no stall) matched, a_position, lcs_length
//
// load and clear take effect in the accept cycle and give no result; busy stays low
// a b item: linear scan of the a-value memory, one entry a cycle, to the first match, then
//   a binary search of the tails memory (search and compare state per probe), then update
// done sits in the cycle after the last step; a new item can be accepted in that cycle
// reset clears counts and control state; memory is never read beyond the loaded counts
module lcs_via_index_map_and_lis
    import lcslis_pkg::*;
#(
    parameter int MAX_A      = 1024,
    parameter int VALUE_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [1:0]                cmd,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      busy,
    output logic                      done,
    output logic                      matched,
    output logic [POS_W-1:0]          a_position,
    output logic [LEN_W-1:0]          lcs_length
);

    dp_cmd_t  dp_cmd;
    dp_stat_t stat;

    lcslis_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .stat   (stat),
        .dp_cmd (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    lcslis_dp #(
        .MAX_A      (MAX_A),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .value      (value),
        .stat       (stat),
        .matched    (matched),
        .a_position (a_position),
        .lcs_length (lcs_length)
    );

endmodule
